### hw/rtl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared payload types, gesture codes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package bgd_pkg;

  // Input transfer: one poll sample
  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  // Output transfer: one gesture event
  typedef struct packed {
    logic [2:0] gesture;
    logic [7:0] clicks_seen;
    logic       last_of_tick;
  } out_t;

  // Gesture codes
  localparam logic [2:0] GestClick      = 3'd0;
  localparam logic [2:0] GestDouble     = 3'd1;
  localparam logic [2:0] GestMulti      = 3'd2;
  localparam logic [2:0] GestLongStart  = 3'd3;
  localparam logic [2:0] GestLongDuring = 3'd4;
  localparam logic [2:0] GestLongStop   = 3'd5;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    RegPressedLevel   = 3'd0,
    RegDebounceMs     = 3'd1,
    RegClickWindowMs  = 3'd2,
    RegLongPressMs    = 3'd3,
    RegMaxClicks      = 3'd4,
    RegLongPressEn    = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic        pressed_level;
    logic [15:0] debounce_ms;
    logic [15:0] click_window_ms;
    logic [15:0] long_press_ms;
    logic [7:0]  max_clicks;
    logic        long_press_enable;
  } cfg_t;

  // Events produced by one sample: up to two
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } ev_pair_t;

  // Result queue sizing
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QLevelW = 3;

endpackage

### hw/rtl/bgd_core.sv
// ----------------------------------------------------------------------------
// Button gesture detector core
// Gesture state machine, phase timestamp and click tally; one sample a cycle while step_i is set.
// ----------------------------------------------------------------------------
module bgd_core import bgd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_t      item_i,
  input  cfg_t     cfg_i,
  output ev_pair_t ev_o
);

  typedef enum logic [2:0] {
    StIdle     = 3'd0,
    StPressed  = 3'd1,
    StPressRel = 3'd2,
    StCounting = 3'd3,
    StLong     = 3'd4,
    StLongRel  = 3'd5
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] start_q, start_d;
  logic [7:0]  tally_q, tally_d;

  logic        pressed;
  logic [31:0] elapsed;
  logic        debounce_ok, window_ok, long_ok;

  assign pressed     = (item_i.pin_level == cfg_i.pressed_level);
  assign elapsed     = item_i.now_ms - start_q;
  assign debounce_ok = (elapsed >= {16'd0, cfg_i.debounce_ms});
  assign window_ok   = (elapsed >= {16'd0, cfg_i.click_window_ms});
  assign long_ok     = (elapsed >  {16'd0, cfg_i.long_press_ms});

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    tally_d = tally_q;
    ev_o.count  = 2'd0;
    ev_o.first  = '{gesture: GestClick, clicks_seen: tally_q, last_of_tick: 1'b1};
    ev_o.second = '{gesture: GestLongDuring, clicks_seen: tally_q, last_of_tick: 1'b1};
    case (state_q)
      StIdle: begin
        if (pressed) begin
          state_d = StPressed;
          start_d = item_i.now_ms;
          tally_d = 8'd0;
        end
      end
      StPressed: begin
        if (pressed) begin
          if (cfg_i.long_press_enable && long_ok) begin
            ev_o.count              = 2'd2;
            ev_o.first.gesture      = GestLongStart;
            ev_o.first.last_of_tick = 1'b0;
            state_d                 = StLong;
          end
        end else if (debounce_ok) begin
          state_d = StPressRel;
          start_d = item_i.now_ms;
        end
      end
      StPressRel: begin
        if (!pressed && debounce_ok) begin
          tally_d = tally_q + 8'd1;
          state_d = StCounting;
        end
      end
      StCounting: begin
        if (pressed) begin
          state_d = StPressed;
          start_d = item_i.now_ms;
        end else if (window_ok || (tally_q == cfg_i.max_clicks)) begin
          ev_o.count = 2'd1;
          if (tally_q == 8'd1) begin
            ev_o.first.gesture = GestClick;
          end else if (tally_q == 8'd2) begin
            ev_o.first.gesture = GestDouble;
          end else begin
            ev_o.first.gesture = GestMulti;
          end
          state_d = StIdle;
          start_d = 32'd0;
          tally_d = 8'd0;
        end
      end
      StLong: begin
        if (pressed) begin
          if (cfg_i.long_press_enable) begin
            ev_o.count         = 2'd1;
            ev_o.first.gesture = GestLongDuring;
          end
        end else begin
          state_d = StLongRel;
          start_d = item_i.now_ms;
        end
      end
      StLongRel: begin
        if (!pressed && debounce_ok) begin
          if (cfg_i.long_press_enable) begin
            ev_o.count         = 2'd1;
            ev_o.first.gesture = GestLongStop;
          end
          state_d = StIdle;
          start_d = 32'd0;
          tally_d = 8'd0;
        end
      end
      default: begin
        state_d = StIdle;
        start_d = 32'd0;
        tally_d = 8'd0;
      end
    endcase
    if (!step_i) begin
      ev_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      start_q <= 32'd0;
      tally_q <= 8'd0;
    end else if (step_i) begin
      state_q <= state_d;
      start_q <= start_d;
      tally_q <= tally_d;
    end
  end

endmodule

### hw/rtl/bgd_out_fifo.sv
// ----------------------------------------------------------------------------
// Button gesture detector result queue
// Four-entry queue taking up to two events a cycle and handing out one while the reader is ready.
// ----------------------------------------------------------------------------
module bgd_out_fifo import bgd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ev_pair_t           push_i,
  output logic [QLevelW-1:0] level_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  out_t               mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QLevelW-1:0] level_q;
  logic               pop;
  logic [QPtrW-1:0]   wr_next;

  assign level_o     = level_q;
  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_next     = wr_q + QPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + QPtrW'(push_i.count);
      rd_q    <= rd_q + QPtrW'(pop);
      level_q <= level_q + QLevelW'(push_i.count) - QLevelW'(pop);
    end
  end

endmodule

### hw/rtl/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// Button gesture detector
// Turns poll samples of a button pin into click, double, multi and long events.
// ----------------------------------------------------------------------------
// Each input transfer is one poll sample (pin level and a millisecond
// timestamp). A sample is taken into an input register and, once the result
// queue has room, runs through the gesture state machine in a single pass:
// one 32-bit subtraction for elapsed time and three compares against the
// configured time thresholds. A sample can be accepted every cycle; it yields
// zero, one or two gesture events, which go into a four-entry result queue
// whose head drives the output transfer. The only thing that holds a sample
// back is the queue having fewer than two free entries, so sustained rate is
// one sample per cycle while events are taken as fast as they are produced,
// and one event per cycle at the output. Configuration registers are written
// through a plain write port and should only change while the block is idle.
// ----------------------------------------------------------------------------
module button_gesture_detector import bgd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  // gesture output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               item_valid_q;
  in_t                item_q;
  logic               advance;
  logic [QLevelW-1:0] level;
  ev_pair_t           ev;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressed_level     <= 1'b0;
      cfg_q.debounce_ms       <= 16'd50;
      cfg_q.click_window_ms   <= 16'd400;
      cfg_q.long_press_ms     <= 16'd800;
      cfg_q.max_clicks        <= 8'd1;
      cfg_q.long_press_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        RegPressedLevel:  cfg_q.pressed_level     <= cfg_wdata_i[0];
        RegDebounceMs:    cfg_q.debounce_ms       <= cfg_wdata_i;
        RegClickWindowMs: cfg_q.click_window_ms   <= cfg_wdata_i;
        RegLongPressMs:   cfg_q.long_press_ms     <= cfg_wdata_i;
        RegMaxClicks:     cfg_q.max_clicks        <= cfg_wdata_i[7:0];
        RegLongPressEn:   cfg_q.long_press_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance the held sample only when the queue has room for two events,
  // so the worst case of a single sample always fits
  assign advance    = item_valid_q && (level <= QLevelW'(QDepth - 2));
  assign in_ready_o = !item_valid_q || advance;

  // Input register: hold the sample until the state machine takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  bgd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .ev_o   (ev)
  );

  bgd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ev),
    .level_o     (level),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // An accepted sample sits in the input register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> item_valid_q)
    else $error("accepted sample not held in input register");

  // The queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QLevelW'(QDepth))
    else $error("result queue overflow");

  // An event produced shows up at the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev.count != 2'd0) |=> out_valid_o)
    else $error("produced event not presented");

  // Events are only produced for a sample that is being processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev.count != 2'd0) |-> advance)
    else $error("event produced without a sample");

endmodule
